// ----- rtl/core/pcab_pkg.sv -----
// Package: shared types, constants and tables for the angle-bin min-range block
`default_nettype none
package pcab_pkg;

  localparam int BINS_DEF       = 1440;
  localparam int COORD_BITS_DEF = 20;
  localparam int CORDIC_ITERS   = 28;
  localparam int RANGE_W        = 20;
  localparam int CFG_W          = 20;
  localparam int CFG_IDX_W      = 4;
  localparam int RB_W           = 11;
  localparam logic [RANGE_W-1:0] RESET_FILL = 20'd31000;
  localparam logic [RANGE_W:0]   FILL_ADD   = 21'd1000;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_LOW  = 4'd0;
  localparam logic [CFG_IDX_W-1:0] REG_HEIGHT_HIGH = 4'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_LOW   = 4'd2;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_X_HIGH  = 4'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_LOW   = 4'd4;
  localparam logic [CFG_IDX_W-1:0] REG_BOX_Y_HIGH  = 4'd5;
  localparam logic [CFG_IDX_W-1:0] REG_NEAR_LIMIT  = 4'd6;
  localparam logic [CFG_IDX_W-1:0] REG_FAR_LIMIT   = 4'd7;

  localparam logic ACT_ADD  = 1'b0;
  localparam logic ACT_READ = 1'b1;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_DEC, S_FILT, S_SUM, S_CHECK, S_ITER,
    S_BIN, S_RDA, S_RDD, S_UPD, S_RRA, S_RRD
  } state_t;

  typedef enum logic [1:0] {A_CNT, A_BIN, A_RD} addr_sel_t;
  typedef enum logic [1:0] {W_INIT, W_FILL, W_ROOT} wdata_sel_t;

  typedef struct packed {
    logic       latch;
    logic       sq_en;
    logic       sum_en;
    logic       init_en;
    logic       iter_en;
    logic       bin_en;
    logic       cur_sq_en;
    logic       out_load;
    logic       ram_we;
    logic       cnt_clr;
    logic       cnt_inc;
    addr_sel_t  asel;
    wdata_sel_t wsel;
  } cmd_t;

  typedef struct packed {
    logic action;
    logic pvalid;
    logic rd_ok;
    logic drop;
    logic clear_done;
    logic iter_done;
    logic upd;
  } stat_t;

  // atan(2^-i) in units of 2^-32 turn
  function automatic logic [31:0] atan_turn(input logic [4:0] i);
    logic [31:0] v;
    case (i)
      5'd0:  v = 32'd536870912;
      5'd1:  v = 32'd316933406;
      5'd2:  v = 32'd167458907;
      5'd3:  v = 32'd85004756;
      5'd4:  v = 32'd42667331;
      5'd5:  v = 32'd21354465;
      5'd6:  v = 32'd10679838;
      5'd7:  v = 32'd5340245;
      5'd8:  v = 32'd2670163;
      5'd9:  v = 32'd1335087;
      5'd10: v = 32'd667544;
      5'd11: v = 32'd333772;
      5'd12: v = 32'd166886;
      5'd13: v = 32'd83443;
      5'd14: v = 32'd41722;
      5'd15: v = 32'd20861;
      5'd16: v = 32'd10430;
      5'd17: v = 32'd5215;
      5'd18: v = 32'd2608;
      5'd19: v = 32'd1304;
      5'd20: v = 32'd652;
      5'd21: v = 32'd326;
      5'd22: v = 32'd163;
      5'd23: v = 32'd81;
      5'd24: v = 32'd41;
      5'd25: v = 32'd20;
      5'd26: v = 32'd10;
      5'd27: v = 32'd5;
      default: v = 32'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/pcab_ram.sv -----
// Generic single-port RAM with registered read
`default_nettype none
module pcab_ram #(
  parameter int WIDTH = 20,
  parameter int DEPTH = 1440
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] addr,
  input  wire logic [WIDTH-1:0]         wdata,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule
`default_nettype wire

// ----- rtl/core/pcab_ctrl.sv -----
// Controller state machine: sequences clear pass, point add and bin read
`default_nettype none
module pcab_ctrl (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           start,
  input  wire pcab_pkg::stat_t st,
  output logic                busy,
  output pcab_pkg::cmd_t      cmd
);
  import pcab_pkg::*;

  state_t state_r, state_nxt;

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLEAR;
    end else begin
      state_r <= state_nxt;
    end
  end

  // next state
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (st.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (start) state_nxt = S_DEC;
      S_DEC: begin
        if (st.action == ACT_READ) begin
          state_nxt = st.rd_ok ? S_RRA : S_IDLE;
        end else begin
          state_nxt = st.pvalid ? S_FILT : S_IDLE;
        end
      end
      S_FILT:  state_nxt = S_SUM;
      S_SUM:   state_nxt = S_CHECK;
      S_CHECK: state_nxt = st.drop ? S_IDLE : S_ITER;
      S_ITER:  if (st.iter_done) state_nxt = S_BIN;
      S_BIN:   state_nxt = S_RDA;
      S_RDA:   state_nxt = S_RDD;
      S_RDD:   state_nxt = S_UPD;
      S_UPD:   state_nxt = S_IDLE;
      S_RRA:   state_nxt = S_RRD;
      S_RRD:   state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  // command outputs
  always_comb begin
    cmd      = '0;
    cmd.asel = A_BIN;
    cmd.wsel = W_ROOT;
    busy     = (state_r != S_IDLE);
    case (state_r)
      S_CLEAR: begin
        cmd.asel    = A_CNT;
        cmd.wsel    = W_INIT;
        cmd.ram_we  = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_IDLE:  cmd.latch = start;
      S_FILT:  cmd.sq_en = 1'b1;
      S_SUM:   cmd.sum_en = 1'b1;
      S_CHECK: begin
        cmd.init_en = 1'b1;
        cmd.cnt_clr = 1'b1;
      end
      S_ITER: begin
        cmd.iter_en = 1'b1;
        cmd.cnt_inc = 1'b1;
      end
      S_BIN:   cmd.bin_en = 1'b1;
      S_RDD:   cmd.cur_sq_en = 1'b1;
      S_UPD:   cmd.ram_we = st.upd;
      S_RRA:   cmd.asel = A_RD;
      S_RRD: begin
        cmd.asel     = A_RD;
        cmd.wsel     = W_FILL;
        cmd.ram_we   = 1'b1;
        cmd.out_load = 1'b1;
      end
      default: ;
    endcase
  end
endmodule
`default_nettype wire

// ----- rtl/core/pcab_dp.sv -----
// Datapath: config registers, filters, squares, CORDIC, square root, bin RAM
`default_nettype none
module pcab_dp #(
  parameter int BINS       = pcab_pkg::BINS_DEF,
  parameter int COORD_BITS = pcab_pkg::COORD_BITS_DEF
) (
  input  wire logic                              clk,
  input  wire logic                              rst_n,
  input  wire pcab_pkg::cmd_t                    cmd,
  output pcab_pkg::stat_t                        st,
  input  wire logic                              in_action,
  input  wire logic signed [COORD_BITS-1:0]      in_x_mm,
  input  wire logic signed [COORD_BITS-1:0]      in_y_mm,
  input  wire logic signed [COORD_BITS-1:0]      in_z_mm,
  input  wire logic                              in_point_valid,
  input  wire logic [pcab_pkg::RB_W-1:0]         in_read_bin,
  input  wire logic                              cfg_we,
  input  wire logic [pcab_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  wire logic [pcab_pkg::CFG_W-1:0]        cfg_data,
  output logic                                   out_valid,
  output logic [pcab_pkg::RB_W-1:0]              out_bin_number,
  output logic [pcab_pkg::RANGE_W-1:0]           out_range_mm,
  output logic                                   out_final_bin
);
  import pcab_pkg::*;

  localparam int CB     = COORD_BITS;
  localparam int BIN_W  = $clog2(BINS);
  localparam int CMP_W  = (CB > CFG_W) ? CB : CFG_W;
  localparam int RSQ_W  = 2 * CB;
  localparam int NSQ_W  = 2 * (CFG_W - 1);
  localparam int NC_W   = (RSQ_W > NSQ_W) ? RSQ_W : NSQ_W;
  localparam int CSQ_W  = 2 * RANGE_W;
  localparam int UC_W   = (RSQ_W > CSQ_W) ? RSQ_W : CSQ_W;
  localparam int CW     = CB + 20;
  localparam int ZW     = 34;
  localparam int NSTEP  = (CB > CORDIC_ITERS) ? CB : CORDIC_ITERS;
  localparam int CNT_W  = $clog2((BINS > NSTEP) ? BINS : NSTEP);
  localparam int PROD_W = 32 + BIN_W + 1;

  // configuration registers
  logic signed [CFG_W-1:0] hlow_r, hhigh_r, bxl_r, bxh_r, byl_r, byh_r;
  logic [CFG_W-2:0]        near_r;
  logic [CFG_W-1:0]        far_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      hlow_r  <= -20'sd1200;
      hhigh_r <= 20'sd0;
      bxl_r   <= -20'sd900;
      bxh_r   <= 20'sd900;
      byl_r   <= -20'sd2500;
      byh_r   <= 20'sd2500;
      near_r  <= 19'd900;
      far_r   <= 20'd30000;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_HEIGHT_LOW:  hlow_r  <= cfg_data;
        REG_HEIGHT_HIGH: hhigh_r <= cfg_data;
        REG_BOX_X_LOW:   bxl_r   <= cfg_data;
        REG_BOX_X_HIGH:  bxh_r   <= cfg_data;
        REG_BOX_Y_LOW:   byl_r   <= cfg_data;
        REG_BOX_Y_HIGH:  byh_r   <= cfg_data;
        REG_NEAR_LIMIT:  near_r  <= cfg_data[CFG_W-2:0];
        REG_FAR_LIMIT:   far_r   <= cfg_data;
        default: ;
      endcase
    end
  end

  // saturated refill value
  logic [RANGE_W:0]   fill_sum;
  logic [RANGE_W-1:0] fill_val;
  assign fill_sum = {1'b0, far_r} + FILL_ADD;
  assign fill_val = fill_sum[RANGE_W] ? {RANGE_W{1'b1}} : fill_sum[RANGE_W-1:0];

  // input word latch
  logic                 act_r, pv_r;
  logic signed [CB-1:0] x_r, y_r, z_r;
  logic [RB_W-1:0]      rbin_r;

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      act_r  <= in_action;
      pv_r   <= in_point_valid;
      x_r    <= in_x_mm;
      y_r    <= in_y_mm;
      z_r    <= in_z_mm;
      rbin_r <= in_read_bin;
    end
  end

  // filters and squares
  logic signed [CMP_W-1:0] xe, ye, ze;
  logic [CB-1:0]           ax, ay;
  logic                    band_out, in_box, neg_pi;
  logic [RSQ_W-2:0]        xsq_r, ysq_r;
  logic [NSQ_W-1:0]        nsq_r;
  logic                    flt_drop_r;
  logic [RSQ_W-1:0]        rsq_r;

  assign xe = CMP_W'(x_r);
  assign ye = CMP_W'(y_r);
  assign ze = CMP_W'(z_r);
  assign ax = x_r[CB-1] ? CB'(~x_r + 1'b1) : CB'(x_r);
  assign ay = y_r[CB-1] ? CB'(~y_r + 1'b1) : CB'(y_r);
  assign band_out = (ze > CMP_W'(hhigh_r)) || (ze < CMP_W'(hlow_r));
  assign in_box   = !((xe < CMP_W'(bxl_r)) || (xe > CMP_W'(bxh_r)) ||
                      (ye < CMP_W'(byl_r)) || (ye > CMP_W'(byh_r)));
  assign neg_pi   = (y_r == '0) && x_r[CB-1];

  always_ff @(posedge clk) begin
    if (cmd.sq_en) begin
      xsq_r      <= (RSQ_W-1)'(ax * ax);
      ysq_r      <= (RSQ_W-1)'(ay * ay);
      nsq_r      <= near_r * near_r;
      flt_drop_r <= band_out || in_box || neg_pi;
    end
    if (cmd.sum_en) begin
      rsq_r <= {1'b0, xsq_r} + {1'b0, ysq_r};
    end
  end

  // iteration counter, shared by clear pass and CORDIC / root steps
  logic [CNT_W-1:0] cnt_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else if (cmd.cnt_clr) begin
      cnt_r <= '0;
    end else if (cmd.cnt_inc) begin
      cnt_r <= cnt_r + 1'b1;
    end
  end

  // CORDIC vectoring, one step a cycle
  logic signed [CW-1:0] cx_r, cy_r, x0, y0, xs, ys, cxsh, cysh;
  logic signed [ZW-1:0] cz_r, z0, atan_s;
  logic                 yzero_r;
  logic [4:0]           step;
  logic                 cord_act, sqrt_act;

  assign step     = cnt_r[4:0];
  assign cord_act = (cnt_r < CNT_W'(CORDIC_ITERS));
  assign sqrt_act = (cnt_r < CNT_W'(CB));
  assign xs       = CW'(x_r);
  assign ys       = CW'(y_r);
  assign cxsh     = cx_r >>> step;
  assign cysh     = cy_r >>> step;
  assign atan_s   = $signed({2'b00, atan_turn(step)});

  // quadrant pre-rotation
  always_comb begin
    if (x_r[CB-1]) begin
      if (!y_r[CB-1]) begin
        x0 = ys;  y0 = -xs; z0 = 34'sd1073741824;
      end else begin
        x0 = -ys; y0 = xs;  z0 = -34'sd1073741824;
      end
    end else begin
      x0 = xs; y0 = ys; z0 = '0;
    end
  end

  // square root, one result bit a cycle
  logic [RSQ_W-1:0] src_r;
  logic [CB+1:0]    rem_r, remw, trial;
  logic [CB-1:0]    root_r;

  assign remw  = {rem_r[CB-1:0], src_r[RSQ_W-1 -: 2]};
  assign trial = {root_r, 2'b01};

  always_ff @(posedge clk) begin
    if (cmd.init_en) begin
      cx_r    <= x0 <<< 16;
      cy_r    <= y0 <<< 16;
      cz_r    <= z0;
      yzero_r <= (y_r == '0);
      src_r   <= rsq_r;
      rem_r   <= '0;
      root_r  <= '0;
    end else if (cmd.iter_en) begin
      if (cord_act) begin
        if (cy_r > 0) begin
          cx_r <= cx_r + cysh;
          cy_r <= cy_r - cxsh;
          cz_r <= cz_r + atan_s;
        end else begin
          cx_r <= cx_r - cysh;
          cy_r <= cy_r + cxsh;
          cz_r <= cz_r - atan_s;
        end
      end
      if (sqrt_act) begin
        src_r <= src_r << 2;
        if (remw >= trial) begin
          rem_r  <= remw - trial;
          root_r <= {root_r[CB-2:0], 1'b1};
        end else begin
          rem_r  <= remw;
          root_r <= {root_r[CB-2:0], 1'b0};
        end
      end
    end
  end

  // phase to bin
  logic signed [ZW-1:0] zc;
  logic [31:0]          ph_u;
  logic [PROD_W-1:0]    prod;
  logic [BIN_W-1:0]     bin_raw, bin_r;

  always_comb begin
    if (yzero_r) begin
      zc = '0;
    end else if (cz_r > 34'sd2147483647) begin
      zc = 34'sd2147483647;
    end else if (cz_r < -34'sd2147483648) begin
      zc = -34'sd2147483648;
    end else begin
      zc = cz_r;
    end
  end
  assign ph_u    = {~zc[31], zc[30:0]};
  assign prod    = PROD_W'(ph_u) * PROD_W'(BINS);
  assign bin_raw = prod[32 +: BIN_W];

  always_ff @(posedge clk) begin
    if (cmd.bin_en) begin
      bin_r <= ({1'b0, bin_raw} >= (BIN_W+1)'(BINS)) ? BIN_W'(BINS - 1) : bin_raw;
    end
  end

  // bin RAM
  logic [BIN_W-1:0]   ram_addr;
  logic [RANGE_W-1:0] ram_wdata, ram_rdata;

  always_comb begin
    case (cmd.asel)
      A_CNT:   ram_addr = cnt_r[BIN_W-1:0];
      A_RD:    ram_addr = BIN_W'(rbin_r);
      default: ram_addr = bin_r;
    endcase
    case (cmd.wsel)
      W_INIT:  ram_wdata = RESET_FILL;
      W_FILL:  ram_wdata = fill_val;
      default: ram_wdata = RANGE_W'(root_r);
    endcase
  end

  pcab_ram #(.WIDTH(RANGE_W), .DEPTH(BINS)) u_ram (
    .clk   (clk),
    .we    (cmd.ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // stored range squared for the update compare
  logic [CSQ_W-1:0] cur_sq_r;
  always_ff @(posedge clk) begin
    if (cmd.cur_sq_en) begin
      cur_sq_r <= ram_rdata * ram_rdata;
    end
  end

  // result word
  logic out_valid_r;
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= cmd.out_load;
    end
    if (cmd.out_load) begin
      out_bin_number <= rbin_r;
      out_range_mm   <= ram_rdata;
      out_final_bin  <= (32'(rbin_r) == BINS - 1);
    end
  end
  assign out_valid = out_valid_r;

  // status to controller
  always_comb begin
    st.action     = act_r;
    st.pvalid     = pv_r;
    st.rd_ok      = (32'(rbin_r) < BINS);
    st.drop       = flt_drop_r || (NC_W'(rsq_r) < NC_W'(nsq_r));
    st.clear_done = (cnt_r == CNT_W'(BINS - 1));
    st.iter_done  = (cnt_r == CNT_W'(NSTEP - 1));
    st.upd        = (UC_W'(cur_sq_r) > UC_W'(rsq_r));
  end
endmodule
`default_nettype wire

// ----- rtl/core/point_cloud_to_angle_bin_min_range.sv -----
// Add point: decode, filter, square, sum, check, the CORDIC / root steps (28 CORDIC and
//   COORD_BITS root steps side by side), bin, RAM read and update; read bin: decode, RAM
//   read, then the out_valid strobe (bin below BINS). One word at a time; busy low when idle.
// Reset: synchronous active-low; afterwards a RAM clearing pass writes 31000 to every bin
//   while busy is high. Config writes are taken at any time.
// The receiver cannot stall: each result is valid for exactly one cycle.
`default_nettype none
module point_cloud_to_angle_bin_min_range #(
  parameter int BINS       = pcab_pkg::BINS_DEF,
  parameter int COORD_BITS = pcab_pkg::COORD_BITS_DEF
) (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           start,
  output logic                                busy,
  input  wire logic                           in_action,
  input  wire logic signed [COORD_BITS-1:0]   in_x_mm,
  input  wire logic signed [COORD_BITS-1:0]   in_y_mm,
  input  wire logic signed [COORD_BITS-1:0]   in_z_mm,
  input  wire logic                           in_point_valid,
  input  wire logic [pcab_pkg::RB_W-1:0]      in_read_bin,
  output logic                                out_valid,
  output logic [pcab_pkg::RB_W-1:0]           out_bin_number,
  output logic [pcab_pkg::RANGE_W-1:0]        out_range_mm,
  output logic                                out_final_bin,
  input  wire logic                           cfg_we,
  input  wire logic [pcab_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [pcab_pkg::CFG_W-1:0]     cfg_data
);
  import pcab_pkg::*;

  cmd_t  cmd;
  stat_t st;

  pcab_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .st    (st),
    .busy  (busy),
    .cmd   (cmd)
  );

  pcab_dp #(.BINS(BINS), .COORD_BITS(COORD_BITS)) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .st             (st),
    .in_action      (in_action),
    .in_x_mm        (in_x_mm),
    .in_y_mm        (in_y_mm),
    .in_z_mm        (in_z_mm),
    .in_point_valid (in_point_valid),
    .in_read_bin    (in_read_bin),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .out_valid      (out_valid),
    .out_bin_number (out_bin_number),
    .out_range_mm   (out_range_mm),
    .out_final_bin  (out_final_bin)
  );
endmodule
`default_nettype wire

// ----- verif/point_cloud_to_angle_bin_min_range_tb.sv -----
// Testbench for the angle-bin min-range block: table-driven and random words vs. a predictor
`timescale 1ns / 100ps
`default_nettype none
module point_cloud_to_angle_bin_min_range_tb;
  import pcab_pkg::*;

  localparam int NBINS = BINS_DEF;
  localparam int CW    = COORD_BITS_DEF;
  localparam int NRAND = 1850;

  // index with no register behind it
  localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 4'd9;

  typedef struct {
    logic          act;
    logic [CW-1:0] x;
    logic [CW-1:0] y;
    logic [CW-1:0] z;
    logic          pv;
    logic [10:0]   rbin;
    logic          chk;     // typed-in range given
    logic [19:0]   rng;
  } word_t;

  typedef struct {
    logic [10:0] bin;
    logic [19:0] rng;
    logic        fin;
    logic        chk;
  } scan_t;

  logic clk, rst_n, start, busy;
  logic in_action, in_point_valid;
  logic signed [CW-1:0] in_x_mm, in_y_mm, in_z_mm;
  logic [RB_W-1:0] in_read_bin;
  logic out_valid, out_final_bin;
  logic [RB_W-1:0] out_bin_number;
  logic [RANGE_W-1:0] out_range_mm;
  logic cfg_we;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0] cfg_data;

  point_cloud_to_angle_bin_min_range dut (.*);

  // predictor state
  longint h_lo, h_hi, bx_lo, bx_hi, by_lo, by_hi;
  longint near_mm, far_mm;
  logic [19:0] min_range [NBINS];
  scan_t pending_scans[$];
  int errors;

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #200ms;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic longint sx(input logic [19:0] v);
    return longint'($signed(v));
  endfunction

  function automatic logic [19:0] fill_range();
    longint f;
    f = far_mm + 1000;
    return (f > 1048575) ? 20'hFFFFF : f[19:0];
  endfunction

  function automatic longint fshr(input longint v, input int s);
    return v >>> s;
  endfunction

  function automatic longint bearing(input longint x, input longint y);
    longint bx, by, ph, nx;
    ph = 0;
    if (y == 0) return 0;
    if (x < 0) begin
      if (y > 0) begin bx = y; by = -x; ph = 1073741824; end
      else begin bx = -y; by = x; ph = -1073741824; end
    end else begin
      bx = x; by = y;
    end
    bx = bx * 65536;
    by = by * 65536;
    for (int i = 0; i < CORDIC_ITERS; i++) begin
      if (by > 0) begin
        nx = bx + fshr(by, i); by = by - fshr(bx, i); ph += longint'(atan_turn(i[4:0]));
      end else begin
        nx = bx - fshr(by, i); by = by + fshr(bx, i); ph -= longint'(atan_turn(i[4:0]));
      end
      bx = nx;
    end
    if (ph > 2147483647) ph = 2147483647;
    if (ph < -64'sd2147483648) ph = -64'sd2147483648;
    return ph;
  endfunction

  function automatic longint root_floor(input longint v);
    longint r;
    r = longint'($sqrt(real'(v)));
    while (r * r > v) r--;
    while ((r + 1) * (r + 1) <= v) r++;
    return r;
  endfunction

  task automatic report_err(input string msg);
    $display("MISMATCH t=%0t: %s", $realtime, msg);
    errors++;
  endtask

  // apply one accepted word to the predicted bin table
  task automatic bin_point(input word_t w);
    longint x, y, z, rsq, ph, b;
    scan_t s;
    if (w.act == ACT_READ) begin
      if (w.rbin >= NBINS) return;
      s.bin = w.rbin;
      s.rng = min_range[w.rbin];
      s.fin = (w.rbin == NBINS - 1);
      s.chk = 1'b1;
      if (w.chk && w.rng != s.rng) report_err("typed-in range disagrees with predictor");
      pending_scans = {pending_scans, s};
      min_range[w.rbin] = fill_range();
      return;
    end
    if (!w.pv) return;
    x = sx(w.x); y = sx(w.y); z = sx(w.z);
    if (z > h_hi || z < h_lo) return;
    if (!(x < bx_lo || x > bx_hi || y < by_lo || y > by_hi)) return;
    rsq = x * x + y * y;
    if (rsq < near_mm * near_mm) return;
    if (y == 0 && x < 0) return;
    ph = bearing(x, y) + 64'sd2147483648;
    b = (ph * NBINS) >>> 32;
    if (b >= NBINS) b = NBINS - 1;
    if (longint'(min_range[b]) * longint'(min_range[b]) > rsq)
      min_range[b] = 20'(root_floor(rsq));
  endtask

  // result checker
  always @(posedge clk) begin
    scan_t e;
    if (rst_n && out_valid) begin
      if (pending_scans.size() == 0) report_err("unexpected word");
      else begin
        e = pending_scans.pop_front();
        if (out_bin_number !== e.bin)
          report_err($sformatf("bin %0d exp %0d", out_bin_number, e.bin));
        if (out_range_mm !== e.rng)
          report_err($sformatf("bin %0d range %0d exp %0d", e.bin, out_range_mm, e.rng));
        if (out_final_bin !== e.fin)
          report_err($sformatf("bin %0d final %0b exp %0b", e.bin, out_final_bin, e.fin));
      end
    end
  end

  task automatic idle_gap();
    int n;
    n = ($urandom_range(0, 9) < 6) ? 0 : ($urandom_range(0, 9) < 8 ?
         $urandom_range(1, 4) : $urandom_range(10, 60));
    repeat (n) @(negedge clk);
  endtask

  task automatic send(input word_t w);
    in_action = w.act; in_x_mm = w.x; in_y_mm = w.y; in_z_mm = w.z;
    in_point_valid = w.pv; in_read_bin = w.rbin;
    start = 1'b1;
    @(posedge clk);
    while (busy) @(posedge clk);
    bin_point(w);
    @(negedge clk);
    start = 1'b0;
  endtask

  task automatic drain();
    int n;
    n = 0;
    while (pending_scans.size() != 0 && n < 10000) begin @(negedge clk); n++; end
    repeat (50) @(negedge clk);  // an add word may still be in flight
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input longint v);
    cfg_we = 1'b1; cfg_index = idx; cfg_data = v[19:0];
    @(negedge clk);
    cfg_we = 1'b0;
    case (idx)
      REG_HEIGHT_LOW:  h_lo = sx(v[19:0]);
      REG_HEIGHT_HIGH: h_hi = sx(v[19:0]);
      REG_BOX_X_LOW:   bx_lo = sx(v[19:0]);
      REG_BOX_X_HIGH:  bx_hi = sx(v[19:0]);
      REG_BOX_Y_LOW:   by_lo = sx(v[19:0]);
      REG_BOX_Y_HIGH:  by_hi = sx(v[19:0]);
      REG_NEAR_LIMIT:  near_mm = v & 20'h7FFFF;
      REG_FAR_LIMIT:   far_mm = v & 20'hFFFFF;
      default: ;
    endcase
  endtask

  function automatic word_t pt(input longint x, input longint y, input longint z,
                               input logic pv);
    word_t w;
    w = '{ACT_ADD, x[CW-1:0], y[CW-1:0], z[CW-1:0], pv, 11'd0, 1'b0, 20'd0};
    return w;
  endfunction

  function automatic word_t rd(input int b, input logic chk, input int r);
    word_t w;
    w = '{ACT_READ, '0, '0, '0, 1'b0, b[10:0], chk, r[19:0]};
    return w;
  endfunction

  function automatic word_t rand_word(input int mode);
    word_t w;
    longint r;
    if ($urandom_range(0, 3) == 0) begin
      w = rd($urandom_range(0, 99) < 95 ? $urandom_range(0, NBINS - 1)
             : $urandom_range(NBINS, 2047), 1'b0, 0);
      return w;
    end
    if (mode == 0) begin
      // z in the default band; x and y within +-r, r 1000..40000, not always beyond box or near limit
      r = $urandom_range(1000, 40000);
      w = pt(longint'($signed($urandom_range(0, 32'(2 * r)))) - r,
             longint'($signed($urandom_range(0, 32'(2 * r)))) - r,
             $urandom_range(0, 1199) * -1, $urandom_range(0, 19) != 0);
    end else begin
      w = pt(sx(20'($urandom())), sx(20'($urandom())), sx(20'($urandom())),
             1'($urandom_range(0, 1)));
    end
    return w;
  endfunction

  word_t dir_tab[$];

  initial begin
    errors = 0;
    rst_n = 1'b0; start = 1'b0; cfg_we = 1'b0; cfg_index = '0; cfg_data = '0;
    in_action = ACT_ADD; in_x_mm = '0; in_y_mm = '0; in_z_mm = '0;
    in_point_valid = 1'b0; in_read_bin = '0;
    h_lo = -1200; h_hi = 0; bx_lo = -900; bx_hi = 900; by_lo = -2500; by_hi = 2500;
    near_mm = 900; far_mm = 30000;
    foreach (min_range[i]) min_range[i] = 20'd31000;
    repeat (2) @(negedge clk);
    rst_n = 1'b1;

    // directed rows
    dir_tab = '{
      rd(0, 1, 31000), rd(NBINS - 1, 1, 31000), rd(NBINS, 0, 0), rd(2047, 0, 0),
      pt(5000, 0, -100, 1), pt(-5000, 0, -100, 1), pt(0, 5000, -100, 1),
      pt(0, -5000, -100, 1), pt(3000, 3000, -100, 0), pt(3000, 3000, -5000, 1),
      pt(900, 2500, -100, 1), pt(100, 2600, -100, 1), pt(-3000, -3000, 0, 1),
      pt(-3000, -3000, -1200, 1), pt(524287, 524287, -100, 1),
      pt(-524288, -524288, -100, 1), pt(-524288, 1, -100, 1), pt(1000, -1, -524288, 1),
      rd(360, 0, 0), rd(720, 0, 0), rd(1080, 0, 0), rd(0, 0, 0), rd(NBINS - 1, 0, 0)
    };
    foreach (dir_tab[i]) begin
      idle_gap();
      send(dir_tab[i]);
    end
    drain();

    // several register settings, extremes included
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: ;
        1: begin
          write_reg(REG_HEIGHT_LOW, -524288); write_reg(REG_HEIGHT_HIGH, 524287);
          write_reg(REG_BOX_X_LOW, 0); write_reg(REG_BOX_X_HIGH, -1);
          write_reg(REG_BOX_Y_LOW, 0); write_reg(REG_BOX_Y_HIGH, -1);
          write_reg(REG_NEAR_LIMIT, 0); write_reg(REG_FAR_LIMIT, 1000000);
          write_reg(REG_UNUSED, 123);
          send(pt(0, 0, 0, 1)); send(rd(NBINS / 2, 0, 0));
          send(rd(NBINS / 2, 0, 0));
        end
        2: begin
          write_reg(REG_NEAR_LIMIT, 524287); write_reg(REG_FAR_LIMIT, 0);
          write_reg(REG_BOX_X_LOW, -524288); write_reg(REG_BOX_X_HIGH, -524288);
        end
        3: begin
          write_reg(REG_HEIGHT_LOW, 100); write_reg(REG_HEIGHT_HIGH, 5000);
          write_reg(REG_NEAR_LIMIT, 2000); write_reg(REG_FAR_LIMIT, 50000);
          write_reg(REG_BOX_X_LOW, -3000); write_reg(REG_BOX_X_HIGH, 3000);
          write_reg(REG_BOX_Y_LOW, -1000); write_reg(REG_BOX_Y_HIGH, 1000);
        end
        default: begin
          write_reg(REG_HEIGHT_LOW, -1200); write_reg(REG_HEIGHT_HIGH, 0);
          write_reg(REG_NEAR_LIMIT, 900); write_reg(REG_FAR_LIMIT, 30000);
          write_reg(REG_BOX_X_LOW, -900); write_reg(REG_BOX_X_HIGH, 900);
          write_reg(REG_BOX_Y_LOW, -2500); write_reg(REG_BOX_Y_HIGH, 2500);
        end
      endcase
      for (int k = 0; k < NRAND / 5; k++) begin
        word_t w;
        w = rand_word($urandom_range(0, 9) < 8 ? 0 : 1);
        if (ph == 3 && w.act == ACT_ADD) w.z = CW'($urandom_range(100, 5000));
        if (k % 150 < 20) send(w);
        else begin idle_gap(); send(w); end
        if (k == 100) drain();  // sender waits out every pending word
      end
      drain();
    end

    if (errors == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/pcab_pkg.sv
rtl/core/pcab_ram.sv
rtl/core/pcab_ctrl.sv
rtl/core/pcab_dp.sv
rtl/core/point_cloud_to_angle_bin_min_range.sv
verif/point_cloud_to_angle_bin_min_range_tb.sv
